// ===== hdl/hed_pkg.sv =====
// shared types, entity tables and constants for the character reference decoder
package hed_pkg;

    localparam int SCAN_WINDOW = 12;
    localparam int NUM_NAMED   = 29;
    localparam int KEY_CHARS_MAX = 6;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic [31:0] CP_MAX      = 32'h0010_FFFF;
    localparam logic [31:0] CP_SURR_LO  = 32'h0000_D800;
    localparam logic [31:0] CP_SURR_HI  = 32'h0000_DFFF;
    localparam logic [31:0] CP_ONE_MAX  = 32'h0000_0080;
    localparam logic [31:0] CP_TWO_MAX  = 32'h0000_0800;
    localparam logic [31:0] CP_THREE_MAX = 32'h0001_0000;

    // input beat as it travels through the queue
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } hed_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_REP,
        ST_FLUSH
    } hed_state_t;

    // entity names, first character in the low byte
    localparam logic [63:0] KEY_CHARS [NUM_NAMED] = '{
        64'("pma"),    64'("tl"),     64'("tg"),     64'("touq"),   64'("sopa"),
        64'("psbn"),   64'("hsadn"),  64'("hsadm"),  64'("ouqsl"),  64'("ouqsr"),
        64'("ouqdl"),  64'("ouqdr"),  64'("llub"),   64'("pilleh"), 64'("ypoc"),
        64'("ger"),    64'("edart"),  64'("ouqal"),  64'("ouqar"),  64'("ged"),
        64'("nmsulp"), 64'("orcim"),  64'("arap"),   64'("toddim"), 64'("21carf"),
        64'("41carf"), 64'("43carf"), 64'("semit"),  64'("edivid")
    };

    localparam logic [2:0] KEY_LEN [NUM_NAMED] = '{
        3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd5, 3'd5, 3'd4, 3'd6, 3'd4, 3'd3, 3'd5, 3'd5, 3'd5, 3'd3,
        3'd6, 3'd5, 3'd4, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd6
    };

    // replacement text, first byte in the low byte
    localparam logic [31:0] SUB_CHARS [NUM_NAMED] = '{
        32'("&"),    32'("<"),    32'(">"),    32'("\""),   32'("'"),
        32'(" "),    32'("-"),    32'("--"),   32'("'"),    32'("'"),
        32'("\""),   32'("\""),   32'("*"),    32'("..."),  32'(")c("),
        32'(")R("),  32'(")MT("), 32'("<<"),   32'(">>"),   32'("ged"),
        32'("-/+"),  32'("u"),    32'("P"),    32'("."),    32'("2/1"),
        32'("4/1"),  32'("4/3"),  32'("x"),    32'("/")
    };

    localparam logic [2:0] SUB_LEN [NUM_NAMED] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3,
        3'd3, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd3, 3'd1, 3'd1
    };

endpackage

// ===== hdl/hed_front.sv =====
// input queue: accepts beats and hands them to the decode engine
module hed_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hed_pkg::hed_item_t in_item,
    output logic               q_valid,
    input  logic               q_pop,
    output hed_pkg::hed_item_t q_item
);

    hed_pkg::hed_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hdl/hed_back.sv =====
// decode engine: hold buffer, reference matching, replay and output stage
module hed_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  hed_pkg::hed_item_t q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               text_end
);

    hed_pkg::hed_state_t state_reg, state_next;

    // held bytes followed by bytes waiting for replay, circular
    logic [7:0] bank_reg [16];
    logic [3:0] head_reg, head_next;
    logic [3:0] fill_reg, fill_next;
    logic [3:0] held_reg, held_next;
    logic       last_reg, last_next;

    logic [31:0] rep_reg, rep_next;
    logic [2:0]  rep_n_reg, rep_n_next;
    logic [1:0]  rep_idx_reg, rep_idx_next;

    logic                           num_reg, num_next;
    logic                           hex_reg, hex_next;
    logic                           stop_reg, stop_next;
    logic [31:0]                    cp_reg, cp_next;
    logic [hed_pkg::NUM_NAMED-1:0]  mask_reg, mask_next;

    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       out_end_reg, out_end_next;

    logic       out_free;
    logic [3:0] rd_idx;
    logic [7:0] cur;
    logic       wr_en;
    logic [3:0] wr_idx;
    logic       emit_en;
    logic [7:0] emit_byte;
    logic       finish_en;

    logic [3:0]  name_len;
    logic [3:0]  pos;
    logic        ok;
    logic [31:0] ok_rep;
    logic [2:0]  ok_n;
    logic        is_dec;
    logic        is_hex_digit;
    logic [3:0]  digit;
    logic [2:0]  pos_lo;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = out_last_reg;
    assign text_end  = out_end_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign rd_idx   = (state_reg == hed_pkg::ST_FLUSH) ? head_reg : head_reg + held_reg;
    assign cur      = bank_reg[rd_idx];
    assign wr_idx   = head_reg + fill_reg;
    assign name_len = held_reg - 4'd1;
    assign pos      = held_reg - 4'd1;
    assign pos_lo   = pos[2:0];

    // digit classification of the byte under the cursor
    always_comb
    begin
        is_dec       = (cur >= 8'h30) && (cur <= 8'h39);
        is_hex_digit = 1'b1;
        digit        = 4'd0;
        if (is_dec)
        begin
            digit = cur[3:0];
        end
        else if ((cur >= 8'h61) && (cur <= 8'h66))
        begin
            digit = cur[3:0] + 4'd9;
        end
        else if ((cur >= 8'h41) && (cur <= 8'h46))
        begin
            digit = cur[3:0] + 4'd9;
        end
        else
        begin
            is_hex_digit = 1'b0;
        end
    end

    // outcome of a closing semicolon
    always_comb
    begin
        ok     = 1'b0;
        ok_rep = 32'd0;
        ok_n   = 3'd0;
        if (num_reg)
        begin
            if ((cp_reg != 32'd0) && (cp_reg <= hed_pkg::CP_MAX))
            begin
                if (cp_reg < hed_pkg::CP_ONE_MAX)
                begin
                    ok     = 1'b1;
                    ok_n   = 3'd1;
                    ok_rep = {24'd0, cp_reg[7:0]};
                end
                else if (cp_reg < hed_pkg::CP_TWO_MAX)
                begin
                    ok     = 1'b1;
                    ok_n   = 3'd2;
                    ok_rep = {16'd0, 2'b10, cp_reg[5:0], 3'b110, cp_reg[10:6]};
                end
                else if (cp_reg < hed_pkg::CP_THREE_MAX)
                begin
                    ok     = !((cp_reg >= hed_pkg::CP_SURR_LO) &&
                               (cp_reg <= hed_pkg::CP_SURR_HI));
                    ok_n   = 3'd3;
                    ok_rep = {8'd0, 2'b10, cp_reg[5:0], 2'b10, cp_reg[11:6],
                              4'b1110, cp_reg[15:12]};
                end
                else
                begin
                    ok     = 1'b1;
                    ok_n   = 3'd4;
                    ok_rep = {2'b10, cp_reg[5:0], 2'b10, cp_reg[11:6],
                              2'b10, cp_reg[17:12], 5'b11110, cp_reg[20:18]};
                end
            end
        end
        else
        begin
            for (int i = 0; i < hed_pkg::NUM_NAMED; i++)
            begin
                if (mask_reg[i] && ({1'b0, hed_pkg::KEY_LEN[i]} == name_len))
                begin
                    ok     = 1'b1;
                    ok_rep = hed_pkg::SUB_CHARS[i];
                    ok_n   = hed_pkg::SUB_LEN[i];
                end
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        held_next    = held_reg;
        last_next    = last_reg;
        rep_next     = rep_reg;
        rep_n_next   = rep_n_reg;
        rep_idx_next = rep_idx_reg;
        num_next     = num_reg;
        hex_next     = hex_reg;
        stop_next    = stop_reg;
        cp_next      = cp_reg;
        mask_next    = mask_reg;
        q_pop        = 1'b0;
        wr_en        = 1'b0;
        emit_en      = 1'b0;
        emit_byte    = cur;
        finish_en    = 1'b0;

        unique case (state_reg)
            hed_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop      = 1'b1;
                    wr_en      = 1'b1;
                    fill_next  = fill_reg + 4'd1;
                    last_next  = q_item.last;
                    state_next = hed_pkg::ST_RUN;
                end
            end
            hed_pkg::ST_RUN:
            begin
                if (out_free)
                begin
                    if (held_reg == fill_reg)
                    begin
                        if (last_reg && (held_reg != 4'd0))
                        begin
                            state_next = hed_pkg::ST_FLUSH;
                        end
                        else
                        begin
                            finish_en  = 1'b1;
                            state_next = hed_pkg::ST_IDLE;
                        end
                    end
                    else if (held_reg == 4'd0)
                    begin
                        if (cur == hed_pkg::CH_AMP)
                        begin
                            held_next = 4'd1;
                            num_next  = 1'b0;
                            hex_next  = 1'b0;
                            stop_next = 1'b0;
                            cp_next   = 32'd0;
                            mask_next = '1;
                        end
                        else
                        begin
                            emit_en   = 1'b1;
                            head_next = head_reg + 4'd1;
                            fill_next = fill_reg - 4'd1;
                        end
                    end
                    else if ((cur == hed_pkg::CH_SEMI) && ok)
                    begin
                        rep_next     = ok_rep;
                        rep_n_next   = ok_n;
                        rep_idx_next = 2'd0;
                        head_next    = head_reg + held_reg + 4'd1;
                        fill_next    = fill_reg - held_reg - 4'd1;
                        held_next    = 4'd0;
                        state_next   = hed_pkg::ST_REP;
                    end
                    else if ((cur == hed_pkg::CH_SEMI) ||
                             (held_reg >= 4'(hed_pkg::SCAN_WINDOW)))
                    begin
                        // give up: literal ampersand, replay the rest
                        emit_en   = 1'b1;
                        emit_byte = hed_pkg::CH_AMP;
                        head_next = head_reg + 4'd1;
                        fill_next = fill_reg - 4'd1;
                        held_next = 4'd0;
                    end
                    else
                    begin
                        held_next = held_reg + 4'd1;
                        for (int i = 0; i < hed_pkg::NUM_NAMED; i++)
                        begin
                            mask_next[i] = mask_reg[i] &&
                                (pos < 4'(hed_pkg::KEY_CHARS_MAX)) &&
                                (hed_pkg::KEY_CHARS[i][{pos_lo, 3'b000} +: 8] == cur);
                        end
                        if (pos == 4'd0)
                        begin
                            num_next = (cur == hed_pkg::CH_HASH);
                        end
                        else if (num_reg && !stop_reg)
                        begin
                            if ((pos == 4'd1) &&
                                ((cur == hed_pkg::CH_LOW_X) || (cur == hed_pkg::CH_UP_X)))
                            begin
                                hex_next = 1'b1;
                            end
                            else if (hex_reg)
                            begin
                                if (is_hex_digit)
                                begin
                                    cp_next = {cp_reg[27:0], digit};
                                end
                                else
                                begin
                                    stop_next = 1'b1;
                                end
                            end
                            else
                            begin
                                if (is_dec)
                                begin
                                    cp_next = {cp_reg[28:0], 3'b000} + {cp_reg[30:0], 1'b0}
                                              + {28'd0, digit};
                                end
                                else
                                begin
                                    stop_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            hed_pkg::ST_REP:
            begin
                if (out_free)
                begin
                    emit_en   = 1'b1;
                    emit_byte = rep_reg[{rep_idx_reg, 3'b000} +: 8];
                    if ({1'b0, rep_idx_reg} == rep_n_reg - 3'd1)
                    begin
                        state_next = hed_pkg::ST_RUN;
                    end
                    else
                    begin
                        rep_idx_next = rep_idx_reg + 2'd1;
                    end
                end
            end
            hed_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    emit_en   = 1'b1;
                    head_next = head_reg + 4'd1;
                    fill_next = fill_reg - 4'd1;
                    held_next = held_reg - 4'd1;
                    if (held_reg == 4'd1)
                    begin
                        state_next = hed_pkg::ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = hed_pkg::ST_IDLE;
            end
        endcase
    end

    // one byte held back so the last one of a run can be marked
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_end_next    = out_end_reg;
        if (finish_en)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = pend_byte_reg;
                out_last_next   = 1'b1;
                out_end_next    = last_reg;
                pend_valid_next = 1'b0;
            end
        end
        else if (emit_en)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                out_last_next  = 1'b0;
                out_end_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hed_pkg::ST_IDLE;
            head_reg       <= 4'd0;
            fill_reg       <= 4'd0;
            held_reg       <= 4'd0;
            last_reg       <= 1'b0;
            rep_n_reg      <= 3'd0;
            rep_idx_reg    <= 2'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            held_reg       <= held_next;
            last_reg       <= last_next;
            rep_n_reg      <= rep_n_next;
            rep_idx_reg    <= rep_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_reg       <= rep_next;
        num_reg       <= num_next;
        hex_reg       <= hex_next;
        stop_reg      <= stop_next;
        cp_reg        <= cp_next;
        mask_reg      <= mask_next;
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_end_reg   <= out_end_next;
        if (wr_en)
        begin
            bank_reg[wr_idx] <= q_item.data;
        end
    end

endmodule

// ===== hdl/html_entity_decoder.sv =====
// top level of the streaming character reference decoder
//
// input channel: in_valid/in_ready carry one text byte per beat in in_byte,
// with text_last high on the final byte of a text
// output channel: out_valid/out_ready carry one decoded byte per beat;
// run_last marks the last byte caused by an input beat, text_end the last
// byte of a whole text; a beat that only extends a held reference gives none
// an ampersand opens a held run of up to 12 bytes; a closing semicolon
// resolves a named or numeric reference, otherwise the ampersand goes out
// literally and the held bytes are scanned again
// a two-beat input queue feeds the decode engine, so new bytes are taken
// while the engine works or the output waits
// the engine takes an ordinary byte through fetch, scan and close, and takes
// a step for each byte emitted or replayed; it scans one byte per cycle
// through its hold buffer while the output is free, which sets the rate;
// bytes pass the queue, hold buffer, held-back byte and output register
// reset clears the queue, hold buffer and output stage, with no held run
// when the receiver stalls, the output register holds its beat, the engine
// waits and the input queue fills and then drops in_ready
module html_entity_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       text_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_end
);

    hed_pkg::hed_item_t in_item;
    hed_pkg::hed_item_t q_item;
    logic               q_valid;
    logic               q_pop;

    assign in_item.data = in_byte;
    assign in_item.last = text_last;

    // front: input beat queue
    hed_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // back: scan, match, replay and output register
    hed_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_end  (text_end)
    );

endmodule
